FILE: rtl/pmf_pkg.sv
// Shared types and constants for the PS/2 mouse packet framer.
package pmf_pkg;

	localparam int FIFO_DEPTH = 32;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CMDQ_DEPTH = 4;

	localparam logic [7:0] SYNC_MASK = 8'h08;
	localparam int         BUTTON_W  = 3;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic [1:0] {
		PH_SYNC,
		PH_X,
		PH_Y
	} phase_t;

	typedef struct packed {
		logic [BUTTON_W-1:0] buttons;
		logic [7:0]          y;
		logic [7:0]          x;
	} pkt_t;

	typedef struct packed {
		logic is_pop;
		pkt_t pkt;
	} cmd_t;

	localparam int PKT_W       = $bits(pkt_t);
	localparam int CMD_W       = $bits(cmd_t);
	localparam int OUT_TDATA_W = ((PKT_W + 7) / 8) * 8;

endpackage

FILE: rtl/pmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/pmf_front.sv
// Front end: takes input words, frames mouse bytes into packets, emits commands.
module pmf_front
	import pmf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_kind,
	input  logic [7:0] in_byte,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	phase_t              phase_q, phase_d;
	logic [BUTTON_W-1:0] flag_q;
	logic [7:0]          x_q;
	logic                accept;

	assign in_ready = cmd_ready;
	assign accept   = in_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
		end else begin
			phase_q <= phase_d;
		end
	end

	// hold the flags and X byte of the packet being framed
	always_ff @(posedge clk) begin
		if (accept && in_kind == KIND_BYTE) begin
			if (phase_q == PH_X) begin
				x_q <= in_byte;
			end else if (phase_q != PH_Y && (in_byte & SYNC_MASK) != 8'h00) begin
				flag_q <= in_byte[BUTTON_W-1:0];
			end
		end
	end

	always_comb begin
		phase_d        = phase_q;
		cmd_valid      = 1'b0;
		cmd.is_pop     = 1'b0;
		cmd.pkt.x      = x_q;
		cmd.pkt.y      = in_byte;
		cmd.pkt.buttons = flag_q;
		if (accept) begin
			if (in_kind == KIND_POP) begin
				cmd_valid  = 1'b1;
				cmd.is_pop = 1'b1;
			end else begin
				unique case (phase_q)
					PH_X: begin
						phase_d = PH_Y;
					end
					PH_Y: begin
						phase_d   = PH_SYNC;
						cmd_valid = 1'b1;
					end
					default: begin
						// drop bytes without the sync bit
						phase_d = ((in_byte & SYNC_MASK) != 8'h00) ? PH_X : PH_SYNC;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/pmf_cmd_queue.sv
// Short command queue between the front end and the packet FIFO engine.
module pmf_cmd_queue
	import pmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	localparam int QP_W = $clog2(CMDQ_DEPTH);
	localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t            slot_q [CMDQ_DEPTH];
	logic [QP_W-1:0] wr_q, rd_q;
	logic [QC_W-1:0] count_q;
	logic            push, pop;

	assign in_ready  = count_q != QC_W'(CMDQ_DEPTH);
	assign out_valid = count_q != '0;
	assign out_cmd   = slot_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QP_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QP_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/pmf_back.sv
// Back end: runs push and pop commands against the packet ring and drives results.
module pmf_back
	import pmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output logic out_avail,
	output pkt_t out_pkt
);

	logic [PTR_W-1:0] wr_q, rd_q, wr_next, rd_next;
	logic             s1_valid_s1, s1_avail_s1;
	logic             s1_adv, s1_free, exec, do_wr, do_rd, ring_empty;
	logic [PKT_W-1:0] rdata;
	pkt_t             rpkt;
	logic             out_valid_q, out_avail_q;
	pkt_t             out_pkt_q;

	assign wr_next    = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
	assign rd_next    = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
	assign ring_empty = rd_q == wr_q;

	assign s1_adv    = s1_valid_s1 && (!out_valid_q || out_ready);
	assign s1_free   = !s1_valid_s1 || s1_adv;
	assign cmd_ready = !cmd.is_pop || s1_free;
	assign exec      = cmd_valid && cmd_ready;
	// drop a finished packet when the ring is full
	assign do_wr     = exec && !cmd.is_pop && (wr_next != rd_q);
	assign do_rd     = exec && cmd.is_pop && !ring_empty;

	pmf_ram #(
		.WIDTH(PKT_W),
		.DEPTH(FIFO_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (do_wr),
		.waddr (wr_q),
		.wdata (cmd.pkt),
		.re    (do_rd),
		.raddr (rd_q),
		.rdata (rdata)
	);

	assign rpkt = pkt_t'(rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_wr) begin
				wr_q <= wr_next;
			end
			if (do_rd) begin
				rd_q <= rd_next;
			end
			if (exec && cmd.is_pop) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec && cmd.is_pop) begin
			s1_avail_s1 <= !ring_empty;
		end
		if (s1_adv) begin
			out_avail_q <= s1_avail_s1;
			out_pkt_q   <= s1_avail_s1 ? rpkt : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_avail = out_avail_q;
	assign out_pkt   = out_pkt_q;

endmodule

FILE: rtl/ps2_mouse_packet_framer_fifo_core.sv
// PS/2 mouse packet framer: top level tying front end, command queue and packet ring.
//
// Input channel s_axis: one word per cycle. tuser selects the kind: 0 carries a
// raw mouse byte in tdata, 1 requests a pop of the oldest stored packet.
// Bytes are framed into three-byte packets; a first byte without the sync bit
// is dropped, and a complete packet is stored in a ring holding FIFO_DEPTH-1
// packets (dropped if the ring is full). Mouse bytes produce no output word.
// Output channel m_axis: one word per pop request. tuser is 1 when a packet was
// popped, 0 when the ring was empty (tdata then reads zero).
// Throughput: one input word per cycle while m_axis does not stall, set by the
// one-command-per-cycle ring engine and the single ring memory port pair. A pop
// request is queued on the accepting edge, then read from the ring, then held in
// the output register before its result shows on m_axis.
// When m_axis stalls, up to CMDQ_DEPTH commands collect in the command queue
// and pops stop at the head; s_axis_tready falls once that queue is full.
// Reset (arst_n low) empties the ring, the queue and the output register and
// returns framing to the sync byte; no clearing pass is needed.
module ps2_mouse_packet_framer_fifo_core
	import pmf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
	input  logic                   s_axis_tuser,   // [0] kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] move_x, [15:8] move_y,
	                                               // [18:16] button_bits, rest zero
	output logic                   m_axis_tuser    // [0] available
);

	logic f_valid, f_ready, b_valid, b_ready;
	cmd_t f_cmd, b_cmd;
	pkt_t out_pkt;

	pmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	pmf_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_cmd   (b_cmd)
	);

	pmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_avail (m_axis_tuser),
		.out_pkt   (out_pkt)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - PKT_W){1'b0}}, out_pkt};

endmodule

FILE: rtl/pmf_checker.sv
// Port-level checks for the PS/2 mouse packet framer, bound to the top level.
module pmf_checker
	import pmf_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [7:0]             s_axis_tdata,
	input logic                   s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// an empty pop reports zero movement and buttons
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("empty pop carries nonzero data");

	// padding above the packet stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:PKT_W] == '0)
		else $error("output padding bits set");

	// the input side keeps taking words while the output side is idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !$past(m_axis_tvalid) && !$past(m_axis_tvalid, 2) &&
		!$past(m_axis_tvalid, 3) && !$past(m_axis_tvalid, 4) && !$past(m_axis_tvalid, 5)
		|-> s_axis_tready)
		else $error("input stalled with output idle");

endmodule

bind ps2_mouse_packet_framer_fifo_core pmf_checker u_pmf_checker (.*);
